FILE: hw/rtl/bmrt_pkg.sv
package bmrt_pkg;

	// Defaults for the top-level parameters
	localparam int DEF_MAX_SRC_WIDTH  = 64;
	localparam int DEF_MAX_SRC_HEIGHT = 64;
	localparam int DEF_MAX_DST_DIM    = 4096;
	localparam int DEF_SAMPLE_BITS    = 16;

	// Fixed field widths
	localparam int FRAC_W      = 16;
	localparam int RATIO_W     = 24;
	localparam int SAMPLE_IN_W = 16;
	localparam int LEVEL_W     = 16;
	localparam int SRC_DIM_W   = 7;
	localparam int DST_DIM_W   = 13;
	localparam int PIXEL_W     = 8;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL      = 3'd4;

	// Configuration reset values
	localparam logic [SRC_DIM_W-1:0]      RST_SRC_WIDTH  = 7'd64;
	localparam logic [SRC_DIM_W-1:0]      RST_SRC_HEIGHT = 7'd64;
	localparam logic [DST_DIM_W-1:0]      RST_DST_WIDTH  = 13'd256;
	localparam logic [DST_DIM_W-1:0]      RST_DST_HEIGHT = 13'd256;
	localparam logic signed [LEVEL_W-1:0] RST_LEVEL      = 16'sd2048;

	// Commands
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_EMIT = 1'b1;

	// Output pixel codes
	localparam logic [PIXEL_W-1:0] PIXEL_OFF = 8'd0;
	localparam logic [PIXEL_W-1:0] PIXEL_ON  = 8'd255;

	typedef struct packed {
		logic                          cmd;
		logic signed [SAMPLE_IN_W-1:0] sample;
	} in_item_t;

	typedef struct packed {
		logic [PIXEL_W-1:0] mask_pixel;
		logic               last_pixel;
	} out_item_t;

	// Divider status toward the controller
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

FILE: hw/rtl/bmrt_store.sv
module bmrt_store import bmrt_pkg::*; #(
	parameter int DEPTH  = DEF_MAX_SRC_WIDTH * DEF_MAX_SRC_HEIGHT,
	parameter int ADDR_W = 12,
	parameter int DATA_W = DEF_SAMPLE_BITS
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [ADDR_W-1:0]        waddr,
	input  logic signed [DATA_W-1:0] wdata,
	input  logic                     re,
	input  logic [ADDR_W-1:0]        raddr,
	output logic signed [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port; hold data between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= $signed(mem[raddr]);
		end
	end

endmodule

FILE: hw/rtl/bmrt_div.sv
module bmrt_div import bmrt_pkg::*; #(
	parameter int DEN_W = 13
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [RATIO_W-1:0] num,
	input  logic [DEN_W-1:0]   den,
	output div_stat_t          stat,
	output logic [RATIO_W-1:0] quo
);

	localparam int CNT_W = $clog2(RATIO_W);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [DEN_W-1:0]   rem_q;
	logic [DEN_W-1:0]   den_q;
	logic [RATIO_W-1:0] shift_q;
	logic [DEN_W:0]     rem_sh;
	logic [DEN_W:0]     rem_dif;
	logic               ge;
	logic [DEN_W-1:0]   rem_nx;

	// One restoring step: shift in the next dividend bit, subtract if it fits
	always_comb begin
		rem_sh  = {rem_q, shift_q[RATIO_W-1]};
		ge      = (rem_sh >= {1'b0, den_q});
		rem_dif = rem_sh - {1'b0, den_q};
		rem_nx  = ge ? rem_dif[DEN_W-1:0] : rem_sh[DEN_W-1:0];
	end

	// Sequence control: one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(RATIO_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// Datapath: dividend shifts out as quotient bits shift in
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q   <= '0;
			den_q   <= den;
			shift_q <= num;
		end else if (busy_q) begin
			rem_q   <= rem_nx;
			shift_q <= {shift_q[RATIO_W-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quo       = shift_q;

endmodule

FILE: hw/rtl/bmrt_lerp.sv
module bmrt_lerp import bmrt_pkg::*; #(
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [SAMPLE_BITS-1:0] a,
	input  logic signed [SAMPLE_BITS-1:0] b,
	input  logic [FRAC_W-1:0]             frac,
	output logic signed [SAMPLE_BITS-1:0] y
);

	localparam int PROD_W = SAMPLE_BITS + FRAC_W + 2;

	logic signed [SAMPLE_BITS:0]   diff;
	logic signed [PROD_W-1:0]      prod;
	logic signed [PROD_W-1:0]      prod_sh;
	logic signed [SAMPLE_BITS+1:0] sum;

	// a + floor((b - a) * frac / 2^16); the result stays between a and b
	always_comb begin
		diff    = $signed({b[SAMPLE_BITS-1], b}) - $signed({a[SAMPLE_BITS-1], a});
		prod    = diff * $signed({1'b0, frac});
		prod_sh = prod >>> FRAC_W;
		sum     = $signed({{2{a[SAMPLE_BITS-1]}}, a}) + $signed(prod_sh[SAMPLE_BITS+1:0]);
	end

	// Register the result
	always_ff @(posedge clk) begin
		if (en) begin
			y <= sum[SAMPLE_BITS-1:0];
		end
	end

endmodule

FILE: hw/rtl/bilinear_mask_resize_threshold.sv
// Bilinear mask resize with threshold.
// Command channel: an item (cmd, sample) transfers on a rising edge with start high and
// busy low. A load command writes the sample at the next store position and leaves busy
// low, so loads can follow back to back. An emit command produces the next target
// pixel in raster order: busy stays high while it steps through its states, and the
// result appears on result with done high for exactly one cycle, registered from the
// final state. A new command can transfer in that same cycle; no new emit is taken
// before the current pixel is done. The four neighbours are read one per cycle from
// the single read port of the sample store; the three lerps share one multiplier.
// The first emit of a raster (column and row both zero) first computes both scale
// ratios on a shared one-bit-per-cycle divider.
// Configuration: a register write transfers on cfg_valid with cfg_ready (always high);
// write only while no emit is in flight. Indexes beyond the register list are ignored.
// Reset clears the counters and ratios and restores register defaults; the sample store
// keeps no reset state and entries must be loaded before they are read.
// Results are not back-pressured: the receiver must take done whenever it pulses.
module bilinear_mask_resize_threshold import bmrt_pkg::*; #(
	parameter int MAX_SRC_WIDTH  = DEF_MAX_SRC_WIDTH,
	parameter int MAX_SRC_HEIGHT = DEF_MAX_SRC_HEIGHT,
	parameter int MAX_DST_DIM    = DEF_MAX_DST_DIM,
	parameter int SAMPLE_BITS    = DEF_SAMPLE_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  in_item_t              item,
	output logic                  done,
	output out_item_t             result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int DEPTH  = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SW_W   = $clog2(MAX_SRC_WIDTH + 1);
	localparam int SH_W   = $clog2(MAX_SRC_HEIGHT + 1);
	localparam int DIM_W  = $clog2(MAX_DST_DIM + 1);
	localparam int XW     = (MAX_SRC_WIDTH > 1) ? $clog2(MAX_SRC_WIDTH) : 1;
	localparam int YW     = (MAX_SRC_HEIGHT > 1) ? $clog2(MAX_SRC_HEIGHT) : 1;
	localparam int CW     = $clog2(MAX_DST_DIM);
	localparam int PX_W   = CW + RATIO_W;
	localparam int IP_W   = PX_W - FRAC_W;
	localparam int CNT_W  = DIM_W + 1;
	localparam int CMP_W  = (SAMPLE_BITS > LEVEL_W) ? SAMPLE_BITS : LEVEL_W;

	typedef enum logic [12:0] {
		ST_IDLE   = 13'b0000000000001,
		ST_DIV_X  = 13'b0000000000010,
		ST_DIV_Y  = 13'b0000000000100,
		ST_MUL    = 13'b0000000001000,
		ST_CLAMP  = 13'b0000000010000,
		ST_BASE   = 13'b0000000100000,
		ST_RD_LT  = 13'b0000001000000,
		ST_RD_RT  = 13'b0000010000000,
		ST_RD_LB  = 13'b0000100000000,
		ST_RD_RB  = 13'b0001000000000,
		ST_LERP_B = 13'b0010000000000,
		ST_LERP_V = 13'b0100000000000,
		ST_FIN    = 13'b1000000000000
	} state_t;

	state_t state_q, state_d;

	// Configuration registers
	logic [SRC_DIM_W-1:0]      src_width_q, src_height_q;
	logic [DST_DIM_W-1:0]      dst_width_q, dst_height_q;
	logic signed [LEVEL_W-1:0] level_q;

	// Control state
	logic [ADDR_W-1:0]  load_idx_q;
	logic [CW-1:0]      col_q, row_q;
	logic [RATIO_W-1:0] ratio_x_q, ratio_y_q;
	logic               done_q;
	out_item_t          result_q;

	// Pipeline and operand registers
	logic [PX_W-1:0]               px_s1, py_s1;
	logic [XW-1:0]                 left_s2, right_s2;
	logic [YW-1:0]                 top_s2, bot_s2;
	logic [FRAC_W-1:0]             fx_s2, fy_s2;
	logic [ADDR_W-1:0]             base_t_s3, base_b_s3;
	logic signed [SAMPLE_BITS-1:0] lt_q, lb_q, tl_q;

	// Combinational
	logic                          accept, is_emit, first_px, last_px;
	logic [SW_W-1:0]               sw;
	logic [SH_W-1:0]               sh;
	logic [DIM_W-1:0]              dw, dh;
	logic [XW-1:0]                 sw_m1, left_c, right_c;
	logic [YW-1:0]                 sh_m1, top_c, bot_c;
	logic [IP_W-1:0]               ix, iy;
	logic                          st_we, st_re;
	logic [ADDR_W-1:0]             st_raddr;
	logic signed [SAMPLE_BITS-1:0] st_rdata, st_wdata;
	logic                          div_start;
	logic [RATIO_W-1:0]            div_num, div_quo;
	logic [DIM_W-1:0]              div_den;
	div_stat_t                     div_stat;
	logic                          lerp_en;
	logic signed [SAMPLE_BITS-1:0] lerp_a, lerp_b, lerp_y;
	logic [FRAC_W-1:0]             lerp_f;
	logic signed [CMP_W-1:0]       v_ext, lvl_ext;

	assign cfg_ready = 1'b1;
	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign is_emit   = (item.cmd == CMD_EMIT);
	assign first_px  = (col_q == '0) && (row_q == '0);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= RST_SRC_WIDTH;
			src_height_q <= RST_SRC_HEIGHT;
			dst_width_q  <= RST_DST_WIDTH;
			dst_height_q <= RST_DST_HEIGHT;
			level_q      <= RST_LEVEL;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SRC_WIDTH:  src_width_q  <= cfg_data[SRC_DIM_W-1:0];
				REG_SRC_HEIGHT: src_height_q <= cfg_data[SRC_DIM_W-1:0];
				REG_DST_WIDTH:  dst_width_q  <= cfg_data[DST_DIM_W-1:0];
				REG_DST_HEIGHT: dst_height_q <= cfg_data[DST_DIM_W-1:0];
				REG_LEVEL:      level_q      <= $signed(cfg_data[LEVEL_W-1:0]);
				default: begin
				end
			endcase
		end
	end

	// Clamp dimensions to their legal ranges
	always_comb begin
		if (src_width_q == '0) sw = SW_W'(1);
		else if (32'(src_width_q) > MAX_SRC_WIDTH) sw = SW_W'(MAX_SRC_WIDTH);
		else sw = SW_W'(src_width_q);

		if (src_height_q == '0) sh = SH_W'(1);
		else if (32'(src_height_q) > MAX_SRC_HEIGHT) sh = SH_W'(MAX_SRC_HEIGHT);
		else sh = SH_W'(src_height_q);

		if (dst_width_q == '0) dw = DIM_W'(1);
		else if (32'(dst_width_q) > MAX_DST_DIM) dw = DIM_W'(MAX_DST_DIM);
		else dw = DIM_W'(dst_width_q);

		if (dst_height_q == '0) dh = DIM_W'(1);
		else if (32'(dst_height_q) > MAX_DST_DIM) dh = DIM_W'(MAX_DST_DIM);
		else dh = DIM_W'(dst_height_q);

		sw_m1 = XW'(sw - 1'b1);
		sh_m1 = YW'(sh - 1'b1);
	end

	// Neighbour coordinates, clamped to the source edges
	always_comb begin
		ix     = px_s1[PX_W-1:FRAC_W];
		iy     = py_s1[PX_W-1:FRAC_W];
		left_c = (ix > IP_W'(sw_m1)) ? sw_m1 : XW'(ix);
		top_c  = (iy > IP_W'(sh_m1)) ? sh_m1 : YW'(iy);
		right_c = ((px_s1[FRAC_W-1:0] != '0) && (left_c < sw_m1)) ? left_c + 1'b1 : left_c;
		bot_c   = ((py_s1[FRAC_W-1:0] != '0) && (top_c < sh_m1)) ? top_c + 1'b1 : top_c;
	end

	// End of row and raster follow the live target dimensions
	assign last_px = (CNT_W'(col_q) + 1'b1 >= CNT_W'(dw))
		&& (CNT_W'(row_q) + 1'b1 >= CNT_W'(dh));

	// Divider: x ratio on the emit transfer, y ratio once x is done
	assign div_start = (accept && is_emit && first_px) || ((state_q == ST_DIV_X) && div_stat.done);
	assign div_num   = (state_q == ST_DIV_X) ? RATIO_W'({sh, {FRAC_W{1'b0}}})
		: RATIO_W'({sw, {FRAC_W{1'b0}}});
	assign div_den   = (state_q == ST_DIV_X) ? dh : dw;

	// Store ports; busy keeps loads out while an emit reads the store
	assign st_we    = accept && !is_emit;
	assign st_wdata = SAMPLE_BITS'(item.sample);

	always_comb begin
		st_re    = 1'b1;
		st_raddr = base_t_s3 + ADDR_W'(left_s2);
		unique case (state_q)
			ST_RD_LT: st_raddr = base_t_s3 + ADDR_W'(left_s2);
			ST_RD_RT: st_raddr = base_t_s3 + ADDR_W'(right_s2);
			ST_RD_LB: st_raddr = base_b_s3 + ADDR_W'(left_s2);
			ST_RD_RB: st_raddr = base_b_s3 + ADDR_W'(right_s2);
			default:  st_re = 1'b0;
		endcase
	end

	// Lerp operand selection: top row, bottom row, then vertical
	always_comb begin
		lerp_en = 1'b0;
		lerp_a  = lt_q;
		lerp_b  = st_rdata;
		lerp_f  = fx_s2;
		unique case (state_q)
			ST_RD_LB: begin
				lerp_en = 1'b1;
			end
			ST_LERP_B: begin
				lerp_en = 1'b1;
				lerp_a  = lb_q;
			end
			ST_LERP_V: begin
				lerp_en = 1'b1;
				lerp_a  = tl_q;
				lerp_b  = lerp_y;
				lerp_f  = fy_s2;
			end
			default: begin
			end
		endcase
	end

	// Threshold compare
	always_comb begin
		v_ext   = CMP_W'(lerp_y);
		lvl_ext = CMP_W'(level_q);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && is_emit) state_d = first_px ? ST_DIV_X : ST_MUL;
			end
			ST_DIV_X: begin
				if (div_stat.done) state_d = ST_DIV_Y;
			end
			ST_DIV_Y: begin
				if (div_stat.done) state_d = ST_MUL;
			end
			ST_MUL:    state_d = ST_CLAMP;
			ST_CLAMP:  state_d = ST_BASE;
			ST_BASE:   state_d = ST_RD_LT;
			ST_RD_LT:  state_d = ST_RD_RT;
			ST_RD_RT:  state_d = ST_RD_LB;
			ST_RD_LB:  state_d = ST_RD_RB;
			ST_RD_RB:  state_d = ST_LERP_B;
			ST_LERP_B: state_d = ST_LERP_V;
			ST_LERP_V: state_d = ST_FIN;
			ST_FIN:    state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Control registers: state, counters, ratios, result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			load_idx_q <= '0;
			col_q      <= '0;
			row_q      <= '0;
			ratio_x_q  <= '0;
			ratio_y_q  <= '0;
			done_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_FIN);
			// Advance the load position, wrapping at the store depth
			if (st_we) begin
				if (load_idx_q == ADDR_W'(DEPTH - 1)) load_idx_q <= '0;
				else load_idx_q <= load_idx_q + 1'b1;
			end
			if ((state_q == ST_DIV_X) && div_stat.done) ratio_x_q <= div_quo;
			if ((state_q == ST_DIV_Y) && div_stat.done) ratio_y_q <= div_quo;
			// Step through the raster; rewind the raster and load counters after the last pixel
			if (state_q == ST_FIN) begin
				if (last_px) begin
					col_q      <= '0;
					row_q      <= '0;
					load_idx_q <= '0;
				end else if (CNT_W'(col_q) + 1'b1 >= CNT_W'(dw)) begin
					col_q <= '0;
					row_q <= row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			px_s1 <= PX_W'(col_q) * PX_W'(ratio_x_q);
			py_s1 <= PX_W'(row_q) * PX_W'(ratio_y_q);
		end
		if (state_q == ST_CLAMP) begin
			left_s2  <= left_c;
			right_s2 <= right_c;
			top_s2   <= top_c;
			bot_s2   <= bot_c;
			fx_s2    <= px_s1[FRAC_W-1:0];
			fy_s2    <= py_s1[FRAC_W-1:0];
		end
		if (state_q == ST_BASE) begin
			base_t_s3 <= ADDR_W'(top_s2) * ADDR_W'(sw);
			base_b_s3 <= ADDR_W'(bot_s2) * ADDR_W'(sw);
		end
		if (state_q == ST_RD_RT) lt_q <= st_rdata;
		if (state_q == ST_RD_RB) begin
			lb_q <= st_rdata;
			tl_q <= lerp_y;
		end
		if (state_q == ST_FIN) begin
			result_q.mask_pixel <= (v_ext < lvl_ext) ? PIXEL_OFF : PIXEL_ON;
			result_q.last_pixel <= last_px;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	bmrt_store #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W),
		.DATA_W (SAMPLE_BITS)
	) u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (load_idx_q),
		.wdata (st_wdata),
		.re    (st_re),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	bmrt_div #(
		.DEN_W (DIM_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.stat   (div_stat),
		.quo    (div_quo)
	);

	bmrt_lerp #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_lerp (
		.clk  (clk),
		.en   (lerp_en),
		.a    (lerp_a),
		.b    (lerp_b),
		.frac (lerp_f),
		.y    (lerp_y)
	);

`ifndef ASSERT_OFF
	a_done_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_FIN))
		else $error("result strobe without a finished pixel");

	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider started while busy");

	a_last_rewinds: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.last_pixel) |-> (col_q == '0 && row_q == '0 && load_idx_q == '0))
		else $error("counters not rewound after last pixel");

	a_ratio_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_DIV_X && state_q != ST_DIV_Y) |=>
		($stable(ratio_x_q) && $stable(ratio_y_q)))
		else $error("ratio changed outside ratio computation");
`endif

endmodule

FILE: dv/bmrt_checker.sv
module bmrt_checker import bmrt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  busy,
	input  in_item_t              item,
	input  logic                  done,
	input  out_item_t             result,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    mismatches,
	output int                    pending,
	output int                    pixels_checked,
	output int                    rasters
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STORE_DEPTH = DEF_MAX_SRC_WIDTH * DEF_MAX_SRC_HEIGHT;
	localparam int MAX_REPORTS = 10;

	// Mirror of the mask store, raster position and latched scale ratios
	logic signed [SAMPLE_IN_W-1:0] mask_mem [STORE_DEPTH];
	int unsigned                   wr_ptr;
	int unsigned                   col;
	int unsigned                   row;
	logic [RATIO_W-1:0]            step_x;
	logic [RATIO_W-1:0]            step_y;

	// Mirror of the register file
	logic [SRC_DIM_W-1:0]          src_w_r;
	logic [SRC_DIM_W-1:0]          src_h_r;
	logic [DST_DIM_W-1:0]          dst_w_r;
	logic [DST_DIM_W-1:0]          dst_h_r;
	logic signed [LEVEL_W-1:0]     level_r;

	out_item_t                     expected_pixels [$];
	out_item_t                     want;
	int                            err_count;
	int                            n_results;
	int                            n_rasters;

	function automatic int unsigned fit_dim(input int unsigned v, input int unsigned hi);
		return (v < 1) ? 1 : ((v > hi) ? hi : v);
	endfunction

	// Unsigned Q8.16 source step per target pixel, saturated to the ratio width
	function automatic logic [RATIO_W-1:0] scale_ratio(input int unsigned s,
			input int unsigned d);
		longint unsigned q;
		q = (longint'(s) << FRAC_W) / d;
		return (q > 64'hFF_FFFF) ? '1 : q[RATIO_W-1:0];
	endfunction

	// a + floor((b - a) * w / 2^16), floor toward minus infinity
	function automatic int blend(input int a, input int b, input int unsigned w);
		longint p;
		p = longint'(b - a) * longint'(w);
		return a + int'(p >>> FRAC_W);
	endfunction

	// Work out the next target pixel and advance the raster position
	function automatic out_item_t resize_pixel();
		int unsigned     sw, sh, dw, dh;
		int unsigned     col_a, col_b, row_a, row_b, fx, fy;
		longint unsigned px, py;
		int              upper, lower, v;
		logic            last;
		out_item_t       r;
		sw = fit_dim(src_w_r, DEF_MAX_SRC_WIDTH);
		sh = fit_dim(src_h_r, DEF_MAX_SRC_HEIGHT);
		dw = fit_dim(dst_w_r, DEF_MAX_DST_DIM);
		dh = fit_dim(dst_h_r, DEF_MAX_DST_DIM);
		// latch the ratios on the first pixel of a raster
		if (col == 0 && row == 0) begin
			step_x = scale_ratio(sw, dw);
			step_y = scale_ratio(sh, dh);
		end
		px = longint'(col) * step_x;
		py = longint'(row) * step_y;
		fx = px[FRAC_W-1:0];
		fy = py[FRAC_W-1:0];
		// clamp neighbours to the source edges
		col_a = ((px >> FRAC_W) > sw - 1) ? sw - 1 : 32'(px >> FRAC_W);
		row_a = ((py >> FRAC_W) > sh - 1) ? sh - 1 : 32'(py >> FRAC_W);
		col_b = (fx != 0 && col_a + 1 <= sw - 1) ? col_a + 1 : col_a;
		row_b = (fy != 0 && row_a + 1 <= sh - 1) ? row_a + 1 : row_a;
		upper = blend(mask_mem[(row_a * sw + col_a) % STORE_DEPTH],
			mask_mem[(row_a * sw + col_b) % STORE_DEPTH], fx);
		lower = blend(mask_mem[(row_b * sw + col_a) % STORE_DEPTH],
			mask_mem[(row_b * sw + col_b) % STORE_DEPTH], fx);
		v = blend(upper, lower, fy);
		last = (col + 1 >= dw) && (row + 1 >= dh);
		r.mask_pixel = (v < int'(level_r)) ? PIXEL_OFF : PIXEL_ON;
		r.last_pixel = last;
		// the live target size decides row and raster ends
		if (last) begin
			col = 0;
			row = 0;
			wr_ptr = 0;
		end else if (col + 1 >= dw) begin
			col = 0;
			row++;
		end else begin
			col++;
		end
		return r;
	endfunction

	function automatic void flag(input string msg);
		err_count++;
		if (err_count <= MAX_REPORTS) $display("mismatch: %s", msg);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr    = 0;
			col       = 0;
			row       = 0;
			step_x    = '0;
			step_y    = '0;
			src_w_r   = RST_SRC_WIDTH;
			src_h_r   = RST_SRC_HEIGHT;
			dst_w_r   = RST_DST_WIDTH;
			dst_h_r   = RST_DST_HEIGHT;
			level_r   = RST_LEVEL;
			err_count = 0;
			n_results = 0;
			n_rasters = 0;
			expected_pixels.delete();
			mismatches     <= 0;
			pending        <= 0;
			pixels_checked <= 0;
			rasters        <= 0;
		end else begin
			// track register writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SRC_WIDTH:  src_w_r = cfg_data[SRC_DIM_W-1:0];
					REG_SRC_HEIGHT: src_h_r = cfg_data[SRC_DIM_W-1:0];
					REG_DST_WIDTH:  dst_w_r = cfg_data[DST_DIM_W-1:0];
					REG_DST_HEIGHT: dst_h_r = cfg_data[DST_DIM_W-1:0];
					REG_LEVEL:      level_r = cfg_data[LEVEL_W-1:0];
					default: ;
				endcase
			end
			// compare each result transfer against the oldest prediction
			if (done) begin
				n_results++;
				if (expected_pixels.size() == 0) begin
					flag($sformatf("result %0d with none expected (mask %0d, last %0d)",
						n_results, result.mask_pixel, result.last_pixel));
				end else begin
					want = expected_pixels.pop_front();
					if (result.mask_pixel !== want.mask_pixel)
						flag($sformatf("result %0d mask_pixel expected %0d, got %0d",
							n_results, want.mask_pixel, result.mask_pixel));
					if (result.last_pixel !== want.last_pixel)
						flag($sformatf("result %0d last_pixel expected %0d, got %0d",
							n_results, want.last_pixel, result.last_pixel));
					if (want.last_pixel) n_rasters++;
				end
			end
			// apply each command transfer to the mirror
			if (start && !busy) begin
				if (item.cmd == CMD_LOAD) begin
					mask_mem[wr_ptr] = item.sample;
					wr_ptr = (wr_ptr + 1) % STORE_DEPTH;
				end else begin
					expected_pixels.push_back(resize_pixel());
				end
			end
			mismatches     <= err_count;
			pending        <= expected_pixels.size();
			pixels_checked <= n_results;
			rasters        <= n_rasters;
		end
	end

endmodule

FILE: dv/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import bmrt_pkg::*;

	localparam int SETTLE_CYCLES = 16;
	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int RANDOM_ITEMS  = 650;
	localparam int STORE_WORDS   = DEF_MAX_SRC_WIDTH * DEF_MAX_SRC_HEIGHT;
	localparam int FINISH_GUARD  = 64;

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  start     = 1'b0;
	logic                  busy;
	in_item_t              item      = '0;
	logic                  done;
	out_item_t             result;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	int mismatches;
	int pending;
	int pixels_checked;
	int rasters;

	bit idle_on;
	int loads_sent;
	int emits_sent;
	int settings;
	int cycles;

	bilinear_mask_resize_threshold u_dut (
		.clk,
		.arst_n,
		.start,
		.busy,
		.item,
		.done,
		.result,
		.cfg_valid,
		.cfg_ready,
		.cfg_index,
		.cfg_data
	);

	bmrt_checker u_checker (
		.clk,
		.arst_n,
		.start,
		.busy,
		.item,
		.done,
		.result,
		.cfg_valid,
		.cfg_ready,
		.cfg_index,
		.cfg_data,
		.mismatches,
		.pending,
		.pixels_checked,
		.rasters
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("testbench: errors");
			$finish;
		end
	end

	// Issue one command; start stays up when the next one follows with no gap
	task automatic send(input logic c, input logic [SAMPLE_IN_W-1:0] s);
		int unsigned gap;
		gap = idle_on ? $urandom_range(0, 9) : 0;
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item  <= '{cmd: c, sample: s};
		do @(posedge clk); while (busy);
		if (c == CMD_EMIT) emits_sent++;
		else loads_sent++;
	endtask

	// Write one register; the caller drops cfg_valid after the last write
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Hold off commands until every predicted pixel has come back
	task automatic wait_results();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic settle();
		wait_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Emit one pixel at a time until the current raster closes or the guard limit is reached
	task automatic finish_raster();
		int r0;
		int guard;
		r0 = rasters;
		guard = 0;
		do begin
			send(CMD_EMIT, SAMPLE_IN_W'($urandom()));
			wait_results();
			guard++;
		end while (rasters == r0 && guard < FINISH_GUARD);
	endtask

	// Dimension word, sometimes with stray bits above the field
	function automatic logic [CFG_DATA_W-1:0] dim_word(input int unsigned v, input int w);
		logic [CFG_DATA_W-1:0] d;
		d = CFG_DATA_W'(v);
		if ($urandom_range(0, 3) == 0) d = d | (CFG_DATA_W'($urandom()) << w);
		return d;
	endfunction

	function automatic int unsigned pick_src();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return $urandom_range(DEF_MAX_SRC_WIDTH + 1, 127);
			2: return DEF_MAX_SRC_WIDTH;
			default: return $urandom_range(1, 8);
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_level();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			default: return CFG_DATA_W'($urandom());
		endcase
	endfunction

	// One setting: fresh mask, a whole raster, sometimes reshaped midway
	task automatic random_phase();
		int unsigned sw, sh, dw, dh, n, pixels, split;
		bit big;
		idle_on = ($urandom_range(0, 3) != 0);
		sw = pick_src();
		sh = pick_src();
		big = ($urandom_range(0, 9) == 0);
		if (big) begin
			dw = $urandom_range(1000, 8191);
			dh = $urandom_range(1, 8191);
		end else begin
			dw = $urandom_range(1, 8);
			dh = $urandom_range(1, 6);
		end
		write_reg(REG_SRC_WIDTH, dim_word(sw, SRC_DIM_W));
		write_reg(REG_SRC_HEIGHT, dim_word(sh, SRC_DIM_W));
		write_reg(REG_DST_WIDTH, dim_word(dw, DST_DIM_W));
		write_reg(REG_DST_HEIGHT, dim_word(dh, DST_DIM_W));
		write_reg(REG_LEVEL, pick_level());
		cfg_valid <= 1'b0;
		settings++;
		// whole mask for small sources, a partial refresh otherwise
		n = (sw * sh > 0 && sw * sh <= 64) ? sw * sh : $urandom_range(0, 16);
		repeat (n) send(CMD_LOAD, SAMPLE_IN_W'($urandom()));
		pixels = big ? $urandom_range(4, 12) : dw * dh;
		split = (!big && $urandom_range(0, 4) == 0) ? $urandom_range(1, pixels) : pixels;
		repeat (split) begin
			if ($urandom_range(0, 5) == 0) send(CMD_LOAD, SAMPLE_IN_W'($urandom()));
			send(CMD_EMIT, SAMPLE_IN_W'($urandom()));
		end
		// reshape the target mid-raster and run it to its end
		if (big || split < pixels) begin
			settle();
			write_reg(REG_DST_WIDTH, dim_word($urandom_range(1, 6), DST_DIM_W));
			write_reg(REG_DST_HEIGHT, dim_word($urandom_range(1, 4), DST_DIM_W));
			write_reg(REG_LEVEL, pick_level());
			cfg_valid <= 1'b0;
			settings++;
			finish_raster();
		end
		settle();
	endtask

	initial begin
		int base;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill the whole store back to back, wrapping the load pointer
		idle_on = 1'b0;
		send(CMD_LOAD, 16'h7FFF);
		send(CMD_LOAD, 16'h8000);
		send(CMD_LOAD, 16'h0000);
		send(CMD_LOAD, 16'hFFFF);
		repeat (STORE_WORDS + 4) send(CMD_LOAD, SAMPLE_IN_W'($urandom()));

		// Reset settings: first pixels of a 64 to 256 upsample
		idle_on = 1'b1;
		repeat (3) send(CMD_EMIT, SAMPLE_IN_W'($urandom()));
		settle();

		// Narrow the row mid-raster so the column is past the end; lowest level
		write_reg(REG_DST_WIDTH, dim_word(2, DST_DIM_W));
		write_reg(REG_LEVEL, 16'h8000);
		cfg_valid <= 1'b0;
		send(CMD_EMIT, SAMPLE_IN_W'($urandom()));
		settle();

		// Zero target size clamps to one: the next pixel closes the raster
		write_reg(REG_DST_WIDTH, 16'h0000);
		write_reg(REG_DST_HEIGHT, 16'h0000);
		cfg_valid <= 1'b0;
		send(CMD_EMIT, SAMPLE_IN_W'($urandom()));
		settle();

		// Clamped source size, widest target, highest level, unused indexes
		write_reg(REG_SRC_WIDTH, 16'h0000);
		write_reg(REG_SRC_HEIGHT, dim_word(127, SRC_DIM_W));
		write_reg(REG_DST_WIDTH, dim_word(8191, DST_DIM_W));
		write_reg(REG_DST_HEIGHT, dim_word(1, DST_DIM_W));
		write_reg(REG_LEVEL, 16'h7FFF);
		for (int k = REG_LEVEL + 1; k < 2 ** CFG_IDX_W; k++)
			write_reg(CFG_IDX_W'(k), CFG_DATA_W'($urandom()));
		cfg_valid <= 1'b0;
		settings++;
		repeat (3) send(CMD_EMIT, SAMPLE_IN_W'($urandom()));
		settle();

		// Source change mid-raster leaves the ratios latched
		write_reg(REG_SRC_WIDTH, dim_word(127, SRC_DIM_W));
		write_reg(REG_DST_WIDTH, dim_word(1, DST_DIM_W));
		cfg_valid <= 1'b0;
		send(CMD_EMIT, SAMPLE_IN_W'($urandom()));
		settle();

		// Largest upsample, then close the raster
		write_reg(REG_SRC_WIDTH, dim_word(DEF_MAX_SRC_WIDTH, SRC_DIM_W));
		write_reg(REG_SRC_HEIGHT, dim_word(DEF_MAX_SRC_HEIGHT, SRC_DIM_W));
		write_reg(REG_DST_WIDTH, dim_word(DEF_MAX_DST_DIM, DST_DIM_W));
		write_reg(REG_DST_HEIGHT, dim_word(DEF_MAX_DST_DIM, DST_DIM_W));
		write_reg(REG_LEVEL, 16'h0000);
		cfg_valid <= 1'b0;
		settings++;
		repeat (2) send(CMD_EMIT, SAMPLE_IN_W'($urandom()));
		settle();
		write_reg(REG_DST_WIDTH, dim_word(1, DST_DIM_W));
		write_reg(REG_DST_HEIGHT, dim_word(1, DST_DIM_W));
		cfg_valid <= 1'b0;
		send(CMD_EMIT, SAMPLE_IN_W'($urandom()));
		settle();

		// Loads interleaved with emission over a two-sample source
		write_reg(REG_SRC_WIDTH, dim_word(2, SRC_DIM_W));
		write_reg(REG_SRC_HEIGHT, dim_word(1, SRC_DIM_W));
		write_reg(REG_DST_WIDTH, dim_word(3, DST_DIM_W));
		write_reg(REG_DST_HEIGHT, dim_word(1, DST_DIM_W));
		cfg_valid <= 1'b0;
		settings++;
		send(CMD_LOAD, 16'h7FFF);
		send(CMD_LOAD, 16'h8000);
		send(CMD_EMIT, SAMPLE_IN_W'($urandom()));
		send(CMD_LOAD, 16'hFFFF);
		send(CMD_EMIT, SAMPLE_IN_W'($urandom()));
		send(CMD_EMIT, SAMPLE_IN_W'($urandom()));
		settle();

		// Random settings until the item budget is spent
		base = loads_sent + emits_sent;
		while (loads_sent + emits_sent < base + RANDOM_ITEMS) random_phase();
		settle();

		$display("covered %0d loads and %0d pixel requests over %0d register settings",
			loads_sent, emits_sent, settings);
		$display("%0d pixels compared, %0d rasters closed, %0d mismatches",
			pixels_checked, rasters, mismatches);
		if (mismatches == 0 && pending == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule
